FILE: sv/lnt_pkg.sv
// Shared types for the LRU name table: opcodes, cell commands and the
// control word broadcast to the cell row. No dependencies.
package lnt_pkg;

	typedef enum logic [2:0] {
		OP_LOOKUP_VAR = 3'd0,
		OP_LOOKUP_REL = 3'd1,
		OP_ENTER      = 3'd2,
		OP_ENTER_INT  = 3'd3,
		OP_DELETE_REL = 3'd4,
		OP_RESET_MARK = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_NOP    = 3'd0,
		C_CMP    = 3'd1,
		C_NEWEST = 3'd2,
		C_FREE   = 3'd3,
		C_CLR    = 3'd4
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic        by_rel;
		logic        pick_oldest;
		logic        set_mark;
		logic        write;
		logic [63:0] var_key;
		logic [63:0] rel_key;
		logic [31:0] data;
	} cell_ctl_t;

endpackage

FILE: sv/lnt_cell.sv
// One table entry of the LRU name table: tags, data, mark and recency rank.
// Passes a priority token and the selected entry's fields to its neighbor.
// Depends on lnt_pkg.
module lnt_cell
	import lnt_pkg::*;
#(
	parameter int ENTRIES = 16,
	parameter int IDX     = 0,
	parameter int RW      = $clog2(ENTRIES),
	parameter int IW      = $clog2(ENTRIES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  logic [IW-1:0] sel_slot,
	input  logic [RW-1:0] sel_rank,
	input  logic          take_in,
	input  logic [63:0]   rel_in,
	input  logic [31:0]   data_in,
	input  logic [RW-1:0] rank_in,
	input  logic [IW-1:0] idx_in,
	output logic          take_out,
	output logic [63:0]   rel_out,
	output logic [31:0]   data_out,
	output logic [RW-1:0] rank_out,
	output logic [IW-1:0] idx_out
);

	logic          used_q;
	logic          mark_q;
	logic          match_q;
	logic [63:0]   var_q;
	logic [63:0]   rel_q;
	logic [31:0]   data_q;
	logic [RW-1:0] rank_q;
	logic          pick;
	logic          sel;
	logic          me;

	assign pick     = ctl.pick_oldest ? (rank_q == '0) : match_q;
	assign sel      = pick & ~take_in;
	assign take_out = take_in | pick;
	assign rel_out  = rel_in | (sel ? rel_q : 64'd0);
	assign data_out = data_in | (sel ? data_q : 32'd0);
	assign rank_out = rank_in | (sel ? rank_q : '0);
	assign idx_out  = idx_in | (sel ? IW'(IDX) : '0);
	assign me       = (sel_slot == IW'(IDX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			mark_q  <= 1'b0;
			match_q <= 1'b0;
			rel_q   <= 64'd0;
			rank_q  <= RW'(IDX);
		end else begin
			case (ctl.op)
				C_CMP: begin
					match_q <= used_q &&
						(ctl.by_rel ? (rel_q == ctl.rel_key) : (var_q == ctl.var_key));
				end
				C_NEWEST: begin
					if (me) begin
						rank_q <= RW'(ENTRIES - 1);
						if (ctl.set_mark)
							mark_q <= 1'b1;
						if (ctl.write) begin
							used_q <= 1'b1;
							rel_q  <= ctl.rel_key;
						end
					end else if (rank_q > sel_rank) begin
						rank_q <= rank_q - 1'b1;
					end
				end
				C_FREE: begin
					if (me) begin
						rank_q  <= '0;
						mark_q  <= 1'b1;
						used_q  <= 1'b0;
						match_q <= 1'b0;
					end else if (rank_q < sel_rank) begin
						rank_q <= rank_q + 1'b1;
					end
				end
				C_CLR: begin
					mark_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == C_NEWEST && me && ctl.write) begin
			var_q  <= ctl.var_key;
			data_q <= ctl.data;
		end
	end

endmodule

FILE: sv/lru_name_table_unit.sv
// Top level of the LRU name table: request sequencer, internal slot and the
// row of lnt_cell entries. Depends on lnt_pkg and lnt_cell.
//
//  channel  | handshake            | fields
//  request  | start, busy          | opcode, var_key, rel_key, entry_data
//  result   | done (1-cycle pulse) | slot, hit, attrs_invalid, deleted_count, data_out
//
// Steps per request: enter internal, reset marks and unused opcodes run only the
// compare state; lookup adds the select state and, on a hit, the update state; enter
// adds select and update, with a second select to pick the oldest entry on a replace;
// delete relation repeats one select/update pair per freed entry.
// busy is high from acceptance to the cycle before done; a new request can be
// taken in the done cycle. Reset restores ranks to slot order, clears flags.
// The receiver cannot stall; done lasts exactly one cycle.
module lru_name_table_unit
	import lnt_pkg::*;
#(
	parameter int ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     opcode,
	input  logic [63:0]                    var_key,
	input  logic [63:0]                    rel_key,
	input  logic [31:0]                    entry_data,
	output logic                           done,
	output logic [$clog2(ENTRIES+1)-1:0]   slot,
	output logic                           hit,
	output logic                           attrs_invalid,
	output logic [$clog2(ENTRIES+1)-1:0]   deleted_count,
	output logic [31:0]                    data_out
);

	localparam int RW = $clog2(ENTRIES);
	localparam int IW = $clog2(ENTRIES);
	localparam int SW = $clog2(ENTRIES + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_UPD  = 4'b1000
	} state_t;

	state_t        state_q;
	logic [2:0]    op_q;
	logic [63:0]   var_q;
	logic [63:0]   rel_q;
	logic [31:0]   data_q;
	logic          old_q;
	logic [SW-1:0] cnt_q;
	logic [63:0]   int_rel_q;
	logic [IW-1:0] sel_slot_q;
	logic [RW-1:0] sel_rank_q;
	logic [63:0]   sel_rel_q;
	logic [31:0]   sel_data_q;
	logic          done_q;
	logic [SW-1:0] slot_q;
	logic          hit_q;
	logic          attrs_q;
	logic [SW-1:0] dcnt_q;
	logic [31:0]   dout_q;

	cell_ctl_t     ctl;
	logic          take   [ENTRIES+1];
	logic [63:0]   rel_c  [ENTRIES+1];
	logic [31:0]   data_c [ENTRIES+1];
	logic [RW-1:0] rank_c [ENTRIES+1];
	logic [IW-1:0] idx_c  [ENTRIES+1];

	assign take[0]   = 1'b0;
	assign rel_c[0]  = 64'd0;
	assign data_c[0] = 32'd0;
	assign rank_c[0] = '0;
	assign idx_c[0]  = '0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		lnt_cell #(
			.ENTRIES(ENTRIES),
			.IDX    (i),
			.RW     (RW),
			.IW     (IW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel_slot(sel_slot_q),
			.sel_rank(sel_rank_q),
			.take_in (take[i]),
			.rel_in  (rel_c[i]),
			.data_in (data_c[i]),
			.rank_in (rank_c[i]),
			.idx_in  (idx_c[i]),
			.take_out(take[i+1]),
			.rel_out (rel_c[i+1]),
			.data_out(data_c[i+1]),
			.rank_out(rank_c[i+1]),
			.idx_out (idx_c[i+1])
		);
	end

	always_comb begin
		ctl             = '0;
		ctl.var_key     = var_q;
		ctl.rel_key     = rel_q;
		ctl.data        = data_q;
		ctl.by_rel      = (op_q == OP_LOOKUP_REL) || (op_q == OP_DELETE_REL);
		ctl.pick_oldest = old_q;
		case (state_q)
			ST_CMP: begin
				ctl.op = (op_q == OP_RESET_MARK) ? C_CLR : C_CMP;
			end
			ST_UPD: begin
				if (op_q == OP_DELETE_REL) begin
					ctl.op = C_FREE;
				end else begin
					ctl.op       = C_NEWEST;
					ctl.write    = (op_q == OP_ENTER);
					ctl.set_mark = !old_q;
				end
			end
			default: begin
				ctl.op = C_NOP;
			end
		endcase
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = done_q;
	assign slot          = slot_q;
	assign hit           = hit_q;
	assign attrs_invalid = attrs_q;
	assign deleted_count = dcnt_q;
	assign data_out      = dout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			done_q    <= 1'b0;
			old_q     <= 1'b0;
			cnt_q     <= '0;
			int_rel_q <= 64'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMP;
						old_q   <= 1'b0;
						cnt_q   <= '0;
					end
				end
				ST_CMP: begin
					if ((op_q == OP_LOOKUP_VAR) || (op_q == OP_LOOKUP_REL) ||
						(op_q == OP_ENTER) || (op_q == OP_DELETE_REL)) begin
						state_q <= ST_SEL;
					end else begin
						if (op_q == OP_ENTER_INT)
							int_rel_q <= rel_q;
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_SEL: begin
					if (take[ENTRIES]) begin
						state_q <= ST_UPD;
					end else if (op_q == OP_ENTER) begin
						old_q <= 1'b1;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_UPD: begin
					if (op_q == OP_DELETE_REL) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_SEL;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			op_q   <= opcode;
			var_q  <= var_key;
			rel_q  <= rel_key;
			data_q <= entry_data;
		end
		if (state_q == ST_SEL) begin
			sel_slot_q <= idx_c[ENTRIES];
			sel_rank_q <= rank_c[ENTRIES];
			sel_rel_q  <= rel_c[ENTRIES];
			sel_data_q <= data_c[ENTRIES];
		end
		case (state_q)
			ST_CMP: begin
				slot_q  <= '0;
				hit_q   <= 1'b0;
				attrs_q <= 1'b0;
				dcnt_q  <= '0;
				dout_q  <= 32'd0;
				if (op_q == OP_ENTER_INT) begin
					slot_q  <= SW'(ENTRIES);
					attrs_q <= (int_rel_q != rel_q);
					dout_q  <= data_q;
				end
			end
			ST_SEL: begin
				slot_q  <= '0;
				hit_q   <= 1'b0;
				attrs_q <= 1'b0;
				dcnt_q  <= (op_q == OP_DELETE_REL) ? cnt_q : '0;
				dout_q  <= 32'd0;
			end
			ST_UPD: begin
				slot_q  <= SW'(sel_slot_q);
				dcnt_q  <= '0;
				if (op_q == OP_ENTER) begin
					hit_q   <= !old_q;
					attrs_q <= (sel_rel_q != rel_q);
					dout_q  <= data_q;
				end else begin
					hit_q   <= 1'b1;
					attrs_q <= 1'b0;
					dout_q  <= sel_data_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: test/lru_name_table_unit_tb.sv
// Self-checking testbench for lru_name_table_unit: directed and random table requests
// against an in-bench LRU table predictor. Depends on lnt_pkg and the RTL of the table.
`timescale 1ns / 100ps

module lru_name_table_unit_tb;
	import lnt_pkg::*;

	localparam int ENTRIES = 16;
	localparam int SW = $clog2(ENTRIES + 1);
	localparam int RANDOM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 20;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [63:0] ONES64 = {64{1'b1}};

	typedef struct {
		logic [SW-1:0] slot;
		logic          hit;
		logic          attrs_invalid;
		logic [SW-1:0] deleted_count;
		logic [31:0]   data_out;
	} table_result_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [2:0]    opcode;
	logic [63:0]   var_key;
	logic [63:0]   rel_key;
	logic [31:0]   entry_data;
	logic          done;
	logic [SW-1:0] slot;
	logic          hit;
	logic          attrs_invalid;
	logic [SW-1:0] deleted_count;
	logic [31:0]   data_out;

	// predicted table contents; index ENTRIES is the internal slot
	bit          tbl_used [0:ENTRIES];
	logic [63:0] tbl_var  [0:ENTRIES];
	logic [63:0] tbl_rel  [0:ENTRIES];
	logic [31:0] tbl_data [0:ENTRIES];
	bit          tbl_mark [0:ENTRIES-1];
	int          tbl_rank [0:ENTRIES-1];

	table_result_t pending_results[$];
	table_result_t want;
	logic [63:0]   var_pool [0:23];
	logic [63:0]   rel_pool [0:5];
	int            fail_count;
	int            cycle_count;

	lru_name_table_unit #(.ENTRIES(ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.var_key(var_key),
		.rel_key(rel_key),
		.entry_data(entry_data),
		.done(done),
		.slot(slot),
		.hit(hit),
		.attrs_invalid(attrs_invalid),
		.deleted_count(deleted_count),
		.data_out(data_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void table_clear();
		for (int i = 0; i <= ENTRIES; i++) begin
			tbl_used[i] = 0;
			tbl_var[i] = '0;
			tbl_rel[i] = '0;
			tbl_data[i] = '0;
		end
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_mark[i] = 0;
			tbl_rank[i] = i;
		end
	endfunction

	function automatic void make_newest(input int s);
		int r;
		r = tbl_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_rank[i] > r) tbl_rank[i]--;
		tbl_rank[s] = ENTRIES - 1;
	endfunction

	function automatic void make_oldest(input int s);
		int r;
		r = tbl_rank[s];
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_rank[i] < r) tbl_rank[i]++;
		tbl_rank[s] = 0;
	endfunction

	function automatic int find_used(input logic [63:0] key, input bit by_rel);
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_used[i] && ((by_rel ? tbl_rel[i] : tbl_var[i]) == key)) return i;
		return -1;
	endfunction

	function automatic int find_oldest();
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_rank[i] == 0) return i;
		return 0;
	endfunction

	// returns whether the relation tag of the slot changed
	function automatic logic store_entry(input int s, input logic [63:0] vk,
			input logic [63:0] rk, input logic [31:0] d);
		logic changed;
		changed = (tbl_rel[s] != rk);
		tbl_used[s] = 1;
		tbl_var[s] = vk;
		tbl_rel[s] = rk;
		tbl_data[s] = d;
		return changed;
	endfunction

	function automatic table_result_t predict_request(input logic [2:0] op,
			input logic [63:0] vk, input logic [63:0] rk, input logic [31:0] d);
		table_result_t r;
		int s;
		int freed;
		r = '{default: '0};
		case (op)
		OP_LOOKUP_VAR, OP_LOOKUP_REL: begin
			s = find_used((op == OP_LOOKUP_REL) ? rk : vk, op == OP_LOOKUP_REL);
			if (s >= 0) begin
				tbl_mark[s] = 1;
				make_newest(s);
				r.slot = SW'(s);
				r.hit = 1'b1;
				r.data_out = tbl_data[s];
			end
		end
		OP_ENTER: begin
			s = find_used(vk, 1'b0);
			if (s >= 0) begin
				tbl_mark[s] = 1;
				r.hit = 1'b1;
			end else begin
				s = find_oldest();
			end
			make_newest(s);
			r.attrs_invalid = store_entry(s, vk, rk, d);
			r.slot = SW'(s);
			r.data_out = d;
		end
		OP_ENTER_INT: begin
			r.attrs_invalid = store_entry(ENTRIES, vk, rk, d);
			r.slot = SW'(ENTRIES);
			r.data_out = d;
		end
		OP_DELETE_REL: begin
			freed = 0;
			for (int i = 0; i < ENTRIES; i++) begin
				if (tbl_used[i] && tbl_rel[i] == rk) begin
					tbl_mark[i] = 1;
					make_newest(i);
					tbl_used[i] = 0;
					make_oldest(i);
					freed++;
				end
			end
			r.deleted_count = SW'(freed);
		end
		OP_RESET_MARK: begin
			for (int i = 0; i < ENTRIES; i++) tbl_mark[i] = 0;
		end
		default: ;
		endcase
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: slot %0d", slot);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("slot", 32'(want.slot), 32'(slot));
				check_field("hit", 32'(want.hit), 32'(hit));
				check_field("attrs_invalid", 32'(want.attrs_invalid), 32'(attrs_invalid));
				check_field("deleted_count", 32'(want.deleted_count), 32'(deleted_count));
				check_field("data_out", want.data_out, data_out);
			end
		end
	end

	// start stays high on return so back-to-back requests need no gap
	task automatic send_request(input logic [2:0] op, input logic [63:0] vk,
			input logic [63:0] rk, input logic [31:0] d);
		start <= 1'b1;
		opcode <= op;
		var_key <= vk;
		rel_key <= rk;
		entry_data <= d;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		pending_results.push_back(predict_request(op, vk, rk, d));
	endtask

	task automatic idle_cycles(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_var();
		if ($urandom_range(0, 9) == 0) return rand64();
		return var_pool[$urandom_range(0, 23)];
	endfunction

	function automatic logic [63:0] pick_rel();
		if ($urandom_range(0, 9) == 0) return rand64();
		return rel_pool[$urandom_range(0, 5)];
	endfunction

	task automatic test_empty_table();
		send_request(OP_LOOKUP_VAR, 64'd0, 64'd0, 32'd0);
		send_request(OP_LOOKUP_REL, ONES64, 64'd0, ONES64[31:0]);
		send_request(OP_DELETE_REL, 64'd0, 64'd0, 32'd0);
		send_request(OP_RESET_MARK, ONES64, ONES64, ONES64[31:0]);
		send_request(OP_SPARE_A, ONES64, ONES64, ONES64[31:0]);
		send_request(OP_SPARE_B, 64'd0, 64'd0, 32'd0);
	endtask

	task automatic test_enter_and_lookup();
		// relation tag of a fresh slot is zero, so this enter keeps attributes
		send_request(OP_ENTER, 64'd0, 64'd0, 32'd0);
		send_request(OP_ENTER, ONES64, ONES64, ONES64[31:0]);
		send_request(OP_LOOKUP_VAR, ONES64, 64'd0, 32'd0);
		send_request(OP_LOOKUP_REL, 64'd0, 64'd0, 32'd0);
		send_request(OP_ENTER, 64'd0, ONES64, 32'h5a5a_a5a5);
		send_request(OP_LOOKUP_VAR, 64'd0, 64'd0, 32'd0);
		send_request(OP_RESET_MARK, 64'd0, 64'd0, 32'd0);
	endtask

	task automatic test_internal_slot();
		send_request(OP_ENTER_INT, ONES64, ONES64, ONES64[31:0]);
		send_request(OP_ENTER_INT, 64'h1234, 64'd0, 32'd0);
		// the internal slot is never searched
		send_request(OP_LOOKUP_VAR, 64'h1234, 64'd0, 32'd0);
		send_request(OP_ENTER_INT, 64'h1234, 64'd0, 32'd1);
	endtask

	task automatic test_delete_relation();
		send_request(OP_DELETE_REL, 64'd0, ONES64, 32'd0);
		send_request(OP_LOOKUP_REL, 64'd0, ONES64, 32'd0);
		send_request(OP_ENTER, 64'h77, 64'h99, 32'hdead_beef);
		send_request(OP_DELETE_REL, 64'd0, 64'h99, 32'd0);
	endtask

	// every slot gets one relation, then one delete frees the whole table
	task automatic fill_and_delete(inout int sent);
		logic [63:0] rk;
		rk = pick_rel();
		for (int i = 0; i <= ENTRIES; i++) begin
			send_request(OP_ENTER, rand64(), rk, $urandom);
			sent++;
		end
		send_request(OP_DELETE_REL, rand64(), rk, $urandom);
		sent++;
	endtask

	task automatic random_request();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35)
			send_request(OP_ENTER, pick_var(), pick_rel(), $urandom);
		else if (roll < 52)
			send_request(OP_LOOKUP_VAR, pick_var(), rand64(), $urandom);
		else if (roll < 66)
			send_request(OP_LOOKUP_REL, rand64(), pick_rel(), $urandom);
		else if (roll < 74)
			send_request(OP_ENTER_INT, pick_var(), pick_rel(), $urandom);
		else if (roll < 82)
			send_request(OP_DELETE_REL, rand64(), pick_rel(), $urandom);
		else if (roll < 88)
			send_request(OP_RESET_MARK, rand64(), rand64(), $urandom);
		else if (roll < 92)
			send_request(($urandom_range(0, 1) != 0) ? OP_SPARE_A : OP_SPARE_B,
				rand64(), rand64(), $urandom);
		else
			send_request(3'($urandom_range(0, 7)), rand64(), rand64(), $urandom);
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		bit paused;
		sent = 0;
		paused = 0;
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				wait_for_results();
				paused = 1;
			end
			if ($urandom_range(0, 14) == 0) begin
				fill_and_delete(sent);
			end else begin
				burst = $urandom_range(1, 20);
				for (int i = 0; i < burst; i++) begin
					random_request();
					sent++;
				end
			end
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
		end
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = '0;
		var_key = '0;
		rel_key = '0;
		entry_data = '0;
		fail_count = 0;
		cycle_count = 0;
		table_clear();
		for (int i = 0; i < 24; i++) var_pool[i] = rand64();
		for (int i = 0; i < 6; i++) rel_pool[i] = rand64();
		var_pool[0] = 64'd0;
		var_pool[1] = ONES64;
		rel_pool[0] = 64'd0;
		rel_pool[1] = ONES64;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_enter_and_lookup();
		test_internal_slot();
		test_delete_relation();
		test_random_traffic();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: lru_name_table_unit.f
sv/lnt_pkg.sv
sv/lnt_cell.sv
sv/lru_name_table_unit.sv
test/lru_name_table_unit_tb.sv
